>>> rtl/tpba_pkg.sv
// Package with the shared widths, codes and defaults of the two-pool block allocator.
package tpba_pkg;

    // Fixed field widths of the request and response transactions.
    localparam int BYTES_W  = 24;
    localparam int BLOCK_W  = 13;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 14;
    localparam int CFG_W    = 5;

    // Block size register value after reset (1 KiB blocks).
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd10;

    // Defaults for the top-level parameters.
    localparam int NUM_BLOCKS_DEFAULT = 8192;
    localparam int MAX_ALLOC_DEFAULT  = 64;

    // Request kinds.
    typedef enum logic
    {
        REQ_ALLOC = 1'b0,
        REQ_FREE  = 1'b1
    } req_kind_t;

    // Response status codes.
    typedef enum logic [STATUS_W-1:0]
    {
        ST_GRANTED   = 3'd0,
        ST_NO_SPACE  = 3'd1,
        ST_TOO_LARGE = 3'd2,
        ST_ZERO      = 3'd3,
        ST_FREED     = 3'd4,
        ST_DROPPED   = 3'd5
    } status_t;

endpackage

>>> rtl/tpba_req_if.sv
// Request channel interface of the two-pool block allocator.
interface tpba_req_if
    import tpba_pkg::*;
();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [BYTES_W-1:0] byte_count;
    logic [BLOCK_W-1:0] block_index;

    modport source (output valid, output req_type, output byte_count, output block_index,
                    input ready);
    modport sink (input valid, input req_type, input byte_count, input block_index,
                  output ready);
endinterface

>>> rtl/tpba_rsp_if.sv
// Response channel interface of the two-pool block allocator.
interface tpba_rsp_if
    import tpba_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [BLOCK_W-1:0] granted_block;
    status_t            status;
    logic               last;
    logic [COUNT_W-1:0] free_count;

    modport source (output valid, output granted_block, output status, output last,
                    output free_count, input ready);
    modport sink (input valid, input granted_block, input status, input last,
                  input free_count, output ready);
endinterface

>>> rtl/tpba_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
module tpba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> rtl/two_pool_block_allocator.sv
// Two-pool block allocator: one request at a time. An allocation is accepted, evaluated, then granted
// one block per cycle while responses are taken, from the recycled-stack RAM while it holds entries,
// else fresh. Free, refused and zero-size requests give one registered response from the evaluate
// state. No new request is taken until idle again; response back-pressure stalls evaluate and grant.
// Reset clears the fresh counter and depth, sets the free count to NUM_BLOCKS and block_size_log2
// to 10; the stack RAM is not cleared, since only entries below the stack depth are ever read.
module two_pool_block_allocator
    import tpba_pkg::*;
#(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEFAULT,
    parameter int MAX_ALLOC  = MAX_ALLOC_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    tpba_req_if.sink         req,
    tpba_rsp_if.source       rsp
);

    localparam int IDX_W = $clog2(NUM_BLOCKS);
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int REM_W = $clog2(MAX_ALLOC + 1);

    typedef enum logic [1:0]
    {
        S_IDLE,
        S_EVAL,
        S_GRANT
    } state_t;

    state_t             state_reg;
    logic [CFG_W-1:0]   bsize_log2_reg;
    logic [CNT_W-1:0]   next_fresh_reg;
    logic [CNT_W-1:0]   depth_reg;
    logic [CNT_W-1:0]   free_reg;
    logic               kind_reg;
    logic [BLOCK_W-1:0] index_reg;
    logic [BYTES_W-1:0] need_reg;
    logic [REM_W-1:0]   rem_reg;

    logic               rsp_valid_reg;
    logic [BLOCK_W-1:0] rsp_block_reg;
    status_t            rsp_status_reg;
    logic               rsp_last_reg;
    logic [COUNT_W-1:0] rsp_count_reg;

    logic [BYTES_W-1:0] need_next;
    logic [BYTES_W-1:0] low_mask;
    logic               slot_free;
    logic               eval_fire;
    logic               grant_fire;
    logic               free_drop;
    logic [31:0]        index_ext;
    logic [CNT_W-1:0]   free_inc;
    logic [CNT_W-1:0]   free_dec;
    logic [31:0]        free_ext;
    logic [31:0]        free_inc_ext;
    logic [31:0]        free_dec_ext;
    logic [IDX_W-1:0]   grant_idx;
    logic [31:0]        grant_ext;
    logic [CNT_W-1:0]   depth_m1;
    logic [CNT_W-1:0]   depth_m2;

    logic               ram_we;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [IDX_W-1:0]   ram_rdata;

    // Block count: the byte count rounded up to whole blocks.
    always_comb
    begin
        low_mask  = ~({BYTES_W{1'b1}} << bsize_log2_reg);
        need_next = (req.byte_count >> bsize_log2_reg)
                  + BYTES_W'(|(req.byte_count & low_mask));
    end

    // Handshake conditions and widened copies of counters for the response fields.
    assign slot_free    = !rsp_valid_reg || rsp.ready;
    assign eval_fire    = (state_reg == S_EVAL) && slot_free;
    assign grant_fire   = (state_reg == S_GRANT) && slot_free;
    assign index_ext    = 32'(index_reg);
    assign free_drop    = (index_ext >= 32'(NUM_BLOCKS)) || (free_reg >= CNT_W'(NUM_BLOCKS));
    assign free_inc     = free_reg + CNT_W'(1);
    assign free_dec     = free_reg - CNT_W'(1);
    assign free_ext     = 32'(free_reg);
    assign free_inc_ext = 32'(free_inc);
    assign free_dec_ext = 32'(free_dec);
    assign depth_m1     = depth_reg - CNT_W'(1);
    assign depth_m2     = depth_reg - CNT_W'(2);

    // A granted block comes from the stack top while the stack holds entries, else fresh.
    assign grant_idx = (depth_reg != '0) ? ram_rdata : next_fresh_reg[IDX_W-1:0];
    assign grant_ext = 32'(grant_idx);

    // Stack RAM control: push on an accepted free, prefetch the top ahead of each grant from the stack.
    always_comb
    begin
        ram_we    = eval_fire && (kind_reg == REQ_FREE) && !free_drop;
        ram_re    = 1'b0;
        ram_raddr = depth_m1[IDX_W-1:0];
        if (eval_fire && (kind_reg == REQ_ALLOC) && (depth_reg != '0))
        begin
            ram_re = 1'b1;
        end
        else if (grant_fire && (rem_reg != REM_W'(1)) && (depth_reg >= CNT_W'(2)))
        begin
            ram_re    = 1'b1;
            ram_raddr = depth_m2[IDX_W-1:0];
        end
    end

    tpba_ram #(
        .WIDTH (IDX_W),
        .DEPTH (NUM_BLOCKS)
    ) u_stack_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (depth_reg[IDX_W-1:0]),
        .wr_data (index_ext[IDX_W-1:0]),
        .rd_en   (ram_re),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    // Sequencer with counters, configuration register and the response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            bsize_log2_reg <= CFG_RESET;
            next_fresh_reg <= '0;
            depth_reg      <= '0;
            free_reg       <= CNT_W'(NUM_BLOCKS);
            kind_reg       <= REQ_ALLOC;
            index_reg      <= '0;
            need_reg       <= '0;
            rem_reg        <= '0;
            rsp_valid_reg  <= 1'b0;
            rsp_block_reg  <= '0;
            rsp_status_reg <= ST_GRANTED;
            rsp_last_reg   <= 1'b0;
            rsp_count_reg  <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                bsize_log2_reg <= cfg_wdata;
            end

            if (rsp_valid_reg && rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        kind_reg  <= req.req_type;
                        index_reg <= req.block_index;
                        need_reg  <= need_next;
                        state_reg <= S_EVAL;
                    end
                end

                S_EVAL:
                begin
                    if (slot_free)
                    begin
                        rsp_block_reg <= '0;
                        rsp_last_reg  <= 1'b1;
                        rsp_count_reg <= free_ext[COUNT_W-1:0];
                        state_reg     <= S_IDLE;
                        if (kind_reg == REQ_FREE)
                        begin
                            rsp_valid_reg <= 1'b1;
                            if (free_drop)
                            begin
                                rsp_status_reg <= ST_DROPPED;
                            end
                            else
                            begin
                                rsp_status_reg <= ST_FREED;
                                rsp_count_reg  <= free_inc_ext[COUNT_W-1:0];
                                depth_reg      <= depth_reg + CNT_W'(1);
                                free_reg       <= free_inc;
                            end
                        end
                        else if (need_reg == '0)
                        begin
                            rsp_valid_reg  <= 1'b1;
                            rsp_status_reg <= ST_ZERO;
                        end
                        else if (need_reg > BYTES_W'(MAX_ALLOC))
                        begin
                            rsp_valid_reg  <= 1'b1;
                            rsp_status_reg <= ST_TOO_LARGE;
                        end
                        else if (need_reg > BYTES_W'(free_reg))
                        begin
                            rsp_valid_reg  <= 1'b1;
                            rsp_status_reg <= ST_NO_SPACE;
                        end
                        else
                        begin
                            rem_reg   <= need_reg[REM_W-1:0];
                            state_reg <= S_GRANT;
                        end
                    end
                end

                S_GRANT:
                begin
                    if (slot_free)
                    begin
                        rsp_valid_reg  <= 1'b1;
                        rsp_block_reg  <= grant_ext[BLOCK_W-1:0];
                        rsp_status_reg <= ST_GRANTED;
                        rsp_last_reg   <= (rem_reg == REM_W'(1));
                        rsp_count_reg  <= free_dec_ext[COUNT_W-1:0];
                        free_reg       <= free_dec;
                        rem_reg        <= rem_reg - REM_W'(1);
                        if (depth_reg != '0)
                        begin
                            depth_reg <= depth_m1;
                        end
                        else
                        begin
                            next_fresh_reg <= next_fresh_reg + CNT_W'(1);
                        end
                        if (rem_reg == REM_W'(1))
                        begin
                            state_reg <= S_IDLE;
                        end
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Channel outputs.
    assign req.ready         = (state_reg == S_IDLE);
    assign rsp.valid         = rsp_valid_reg;
    assign rsp.granted_block = rsp_block_reg;
    assign rsp.status        = rsp_status_reg;
    assign rsp.last          = rsp_last_reg;
    assign rsp.free_count    = rsp_count_reg;

    // The free count always equals the fresh blocks left plus the stack depth.
    a_free_consistent: assert property (@(posedge clk) disable iff (!rst_n)
        32'(free_reg) == (32'(NUM_BLOCKS) - 32'(next_fresh_reg)) + 32'(depth_reg))
        else $error("free count out of step with the fresh counter and stack depth");

    // The free count never exceeds the pool size.
    a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        free_reg <= CNT_W'(NUM_BLOCKS))
        else $error("free count above the number of blocks");

    // A grant sequence never runs with no blocks left to hand out.
    a_grant_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_GRANT) |-> ((rem_reg != '0) && (free_reg != '0)))
        else $error("grant state entered with nothing to grant");

    // The final granted block of a request returns the sequencer to idle.
    a_grant_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (grant_fire && (rem_reg == REM_W'(1))) |=> (state_reg == S_IDLE) && rsp_last_reg)
        else $error("last grant did not end the request");

endmodule
